@@ rtl/two_pool_bitmap_block_allocator_macros.svh @@
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TWO_POOL_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define TWO_POOL_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tpba_pkg.sv @@
// Shared types, constants and codes for the two-pool block allocator.
// No dependencies.
package tpba_pkg;

    // Pool geometry
    localparam int SMALL_WORDS = 16;
    localparam int LARGE_WORDS = 8;
    localparam int TOTAL_WORDS = SMALL_WORDS + LARGE_WORDS;
    localparam int MAX_WORDS   = (SMALL_WORDS > LARGE_WORDS) ? SMALL_WORDS : LARGE_WORDS;
    localparam int MAP_W       = 32;
    localparam int OFS_W       = 5;
    localparam int ADDR_W      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WIDX_W      = $clog2(MAX_WORDS + 1);
    localparam int FIDX_W      = WIDX_W + OFS_W;

    // Field widths
    localparam int SIZE_W  = 24;
    localparam int PRIOR_W = 2;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 9;
    localparam int COUNT_W = 5;
    localparam int BYTES_W = 20;
    localparam int NEED_W  = SIZE_W - 8;

    // Sizing constants
    localparam int SMALL_SHIFT      = 9;          // 0x200 byte blocks
    localparam int SMALL_SIZE_LIMIT = 'h3C01;
    localparam int MAX_RUN          = 31;
    localparam int LARGE_RATIO      = 5;          // 0xA00 = 5 * 0x200
    localparam int LG_NEED_LIMIT    = MAX_RUN * LARGE_RATIO;
    localparam int RECIP5           = 205;        // ceil(1024 / 5)
    localparam int RECIP5_SHIFT     = 10;

    typedef logic [MAP_W-1:0]  t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WIDX_W-1:0] t_widx;
    typedef logic [FIDX_W-1:0] t_fidx;
    typedef logic [OFS_W-1:0]  t_ofs;

    // prior_kind codes
    localparam logic [PRIOR_W-1:0] PRIOR_NONE   = 2'd0;
    localparam logic [PRIOR_W-1:0] PRIOR_SMALL  = 2'd1;
    localparam logic [PRIOR_W-1:0] PRIOR_LARGE  = 2'd2;
    localparam logic [PRIOR_W-1:0] PRIOR_SYSTEM = 2'd3;

    // result_kind codes
    localparam logic [KIND_W-1:0] KIND_SMALL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LARGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYSTEM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FAILED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEED,
        ST_TRY,
        ST_SCAN,
        ST_RESP
    } t_state;

    // Run finder answer for one bitmap word
    typedef struct packed {
        logic  hit;
        t_ofs  offset;
        t_word new_word;
    } t_find;

endpackage

@@ rtl/tpba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpba_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tpba_run_finder.sv @@
// First-fit search for a run of free bits inside one bitmap word.
// Depends on tpba_pkg.
module tpba_run_finder (
    input  tpba_pkg::t_word        i_word,
    input  logic [tpba_pkg::COUNT_W-1:0] i_cnt,
    output tpba_pkg::t_find        o_find
);

    tpba_pkg::t_word                mask;
    logic [tpba_pkg::MAP_W-1:0]     fit;
    tpba_pkg::t_ofs                 ofs;

    // run mask of i_cnt ones; i_cnt is 1..31 when the answer is used
    assign mask = tpba_pkg::t_word'((33'd1 << i_cnt) - 33'd1);

    always_comb begin
        for (int j = 0; j < tpba_pkg::MAP_W; j++) begin
            fit[j] = (((i_word >> j) & mask) == '0)
                  && ((6'(j) + {1'b0, i_cnt}) <= 6'(tpba_pkg::MAP_W));
        end
    end

    // lowest fitting offset wins
    always_comb begin
        ofs = '0;
        for (int j = tpba_pkg::MAP_W - 1; j >= 0; j--) begin
            if (fit[j]) begin
                ofs = tpba_pkg::t_ofs'(j);
            end
        end
    end

    assign o_find.hit      = |fit;
    assign o_find.offset   = ofs;
    assign o_find.new_word = i_word | (mask << ofs);

endmodule

@@ rtl/two_pool_bitmap_block_allocator.sv @@
// Two-pool first-fit bitmap block allocator, top level.
// Depends on tpba_pkg, tpba_ram, tpba_run_finder and the macros header.
//
//  channel   direction  signals                                   handshake
//  request   in         i_request_size, i_prior_kind,             start & !busy
//                       i_in_reserved_range
//  result    out        o_result_kind, o_block_index,             o_valid, 1 cycle
//                       o_block_count, o_byte_offset
//
// One word in, one word out. After acceptance busy stays high through the need
// and try states, any pool scans and the result state. The run finder checks one
// bitmap word per cycle out of the shared map RAM, whose registered read sets
// the pace.
// Synchronous active-low reset marks every map word free (valid bits clear).
// The result receiver cannot stall; o_valid is a single-cycle strobe.
`include "two_pool_bitmap_block_allocator_macros.svh"

module two_pool_bitmap_block_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tpba_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [tpba_pkg::PRIOR_W-1:0]   i_prior_kind,
    input  logic                           i_in_reserved_range,
    output logic                           o_valid,
    output logic [tpba_pkg::KIND_W-1:0]    o_result_kind,
    output logic [tpba_pkg::INDEX_W-1:0]   o_block_index,
    output logic [tpba_pkg::COUNT_W-1:0]   o_block_count,
    output logic [tpba_pkg::BYTES_W-1:0]   o_byte_offset
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    tpba_pkg::t_state r_state, n_state;

    // request context
    logic [tpba_pkg::NEED_W-1:0]  r_sm_need, n_sm_need;     // blocks in small pool
    logic [tpba_pkg::COUNT_W-1:0] r_lg_need, n_lg_need;     // blocks in large pool
    logic                         r_sm_big, n_sm_big;       // small run over 31
    logic                         r_lg_big, n_lg_big;       // large run over 31
    logic                         r_small_first, n_small_first;
    logic [tpba_pkg::PRIOR_W-1:0] r_prior, n_prior;
    logic                         r_reserved, n_reserved;

    // try control
    logic                         r_pool, n_pool;           // 0 small, 1 large
    logic                         r_fallback, n_fallback;   // other pool still allowed
    logic                         r_sys, n_sys;             // straight to system

    // scan pipeline: read issued at r_rd_idx, checked in the following cycle
    tpba_pkg::t_widx              r_rd_idx, n_rd_idx;
    tpba_pkg::t_widx              r_chk_idx, n_chk_idx;
    logic                         r_chk_vld, n_chk_vld;
    logic                         r_q_valid, n_q_valid;

    // per-word written flags; an unwritten word reads as all free
    logic [tpba_pkg::TOTAL_WORDS-1:0] r_valid;

    // result word
    logic [tpba_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [tpba_pkg::INDEX_W-1:0] r_index, n_index;
    logic [tpba_pkg::COUNT_W-1:0] r_count, n_count;
    logic [tpba_pkg::BYTES_W-1:0] r_bytes, n_bytes;

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [tpba_pkg::SIZE_W-1:0]  eff_size;
    logic [tpba_pkg::SIZE_W:0]    size_round;
    logic [8:0]                   lg_num;
    logic [16:0]                  lg_prod;
    tpba_pkg::t_widx              cur_words;
    logic [tpba_pkg::COUNT_W-1:0] try_cnt;
    logic                         try_sys;
    logic                         issue;
    logic                         chk_last;
    logic                         hit;
    logic                         miss_end;
    tpba_pkg::t_addr              rd_addr;
    tpba_pkg::t_addr              wr_addr;
    tpba_pkg::t_word              ram_q;
    tpba_pkg::t_word              chk_word;
    tpba_pkg::t_find              find;
    tpba_pkg::t_fidx              fidx;
    logic [tpba_pkg::FIDX_W+2:0]  fidx_x5;
    logic                         ram_we;

    // zero bytes still takes one block
    assign eff_size   = (i_request_size == '0) ? tpba_pkg::SIZE_W'(1) : i_request_size;
    assign size_round = {1'b0, eff_size} + (tpba_pkg::SIZE_W + 1)'(511);

    // ceil(sm/5) via reciprocal; only meaningful while sm_need <= 155
    assign lg_num  = {1'b0, r_sm_need[7:0]} + 9'd4;
    assign lg_prod = 17'(lg_num) * 17'(tpba_pkg::RECIP5);

    assign cur_words = r_pool ? tpba_pkg::t_widx'(tpba_pkg::LARGE_WORDS)
                              : tpba_pkg::t_widx'(tpba_pkg::SMALL_WORDS);
    assign try_cnt   = r_pool ? r_lg_need : r_sm_need[tpba_pkg::COUNT_W-1:0];
    assign try_sys   = r_sys || (r_pool ? r_lg_big : r_sm_big);

    assign issue    = (r_state == tpba_pkg::ST_SCAN) && (r_rd_idx < cur_words);
    assign chk_last = (r_chk_idx == (cur_words - tpba_pkg::t_widx'(1)));

    // both pools share one RAM: small words first, then large
    assign rd_addr = r_pool ? tpba_pkg::t_addr'(tpba_pkg::SMALL_WORDS) + tpba_pkg::t_addr'(r_rd_idx)
                            : tpba_pkg::t_addr'(r_rd_idx);
    assign wr_addr = r_pool ? tpba_pkg::t_addr'(tpba_pkg::SMALL_WORDS) + tpba_pkg::t_addr'(r_chk_idx)
                            : tpba_pkg::t_addr'(r_chk_idx);

    assign chk_word = r_q_valid ? ram_q : '0;

    assign hit      = (r_state == tpba_pkg::ST_SCAN) && r_chk_vld && find.hit;
    assign miss_end = (r_state == tpba_pkg::ST_SCAN) && r_chk_vld && !find.hit && chk_last;
    assign ram_we   = hit;

    // full run start index, and that index times five for the large pool
    assign fidx    = {r_chk_idx, find.offset};
    assign fidx_x5 = {2'b00, fidx, 1'b0} + {3'b000, fidx} + {1'b0, fidx, 2'b00}
                   - {2'b00, fidx, 1'b0};

    tpba_ram #(
        .WIDTH (tpba_pkg::MAP_W),
        .DEPTH (tpba_pkg::TOTAL_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (find.new_word),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    tpba_run_finder u_finder (
        .i_word (chk_word),
        .i_cnt  (try_cnt),
        .o_find (find)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpba_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = tpba_pkg::ST_NEED;
                end
            end
            tpba_pkg::ST_NEED: begin
                n_state = tpba_pkg::ST_TRY;
            end
            tpba_pkg::ST_TRY: begin
                n_state = try_sys ? tpba_pkg::ST_RESP : tpba_pkg::ST_SCAN;
            end
            tpba_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = tpba_pkg::ST_RESP;
                end else if (miss_end) begin
                    n_state = r_fallback ? tpba_pkg::ST_TRY : tpba_pkg::ST_RESP;
                end
            end
            tpba_pkg::ST_RESP: begin
                n_state = tpba_pkg::ST_IDLE;
            end
            default: begin
                n_state = tpba_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs and datapath updates
    // ---------------------------------------------------------------
    always_comb begin
        n_sm_need     = r_sm_need;
        n_lg_need     = r_lg_need;
        n_sm_big      = r_sm_big;
        n_lg_big      = r_lg_big;
        n_small_first = r_small_first;
        n_prior       = r_prior;
        n_reserved    = r_reserved;
        n_pool        = r_pool;
        n_fallback    = r_fallback;
        n_sys         = r_sys;
        n_rd_idx      = r_rd_idx;
        n_chk_idx     = r_chk_idx;
        n_chk_vld     = 1'b0;
        n_q_valid     = r_q_valid;
        n_kind        = r_kind;
        n_index       = r_index;
        n_count       = r_count;
        n_bytes       = r_bytes;

        case (r_state)
            tpba_pkg::ST_IDLE: begin
                if (start) begin
                    n_sm_need     = size_round[tpba_pkg::SIZE_W:tpba_pkg::SMALL_SHIFT];
                    n_small_first = (eff_size < tpba_pkg::SIZE_W'(tpba_pkg::SMALL_SIZE_LIMIT));
                    n_prior       = i_prior_kind;
                    n_reserved    = i_in_reserved_range;
                end
            end
            tpba_pkg::ST_NEED: begin
                n_lg_need = lg_prod[tpba_pkg::RECIP5_SHIFT +: tpba_pkg::COUNT_W];
                n_sm_big  = (r_sm_need > tpba_pkg::NEED_W'(tpba_pkg::MAX_RUN));
                n_lg_big  = (r_sm_need > tpba_pkg::NEED_W'(tpba_pkg::LG_NEED_LIMIT));
                case (r_prior)
                    tpba_pkg::PRIOR_NONE: begin
                        n_sys      = r_reserved;
                        n_pool     = !r_small_first;
                        n_fallback = 1'b1;
                    end
                    tpba_pkg::PRIOR_SMALL: begin
                        n_sys      = 1'b0;
                        n_pool     = 1'b1;
                        n_fallback = 1'b0;
                    end
                    tpba_pkg::PRIOR_LARGE: begin
                        n_sys      = 1'b0;
                        n_pool     = 1'b0;
                        n_fallback = 1'b0;
                    end
                    default: begin
                        n_sys      = 1'b1;
                        n_pool     = 1'b0;
                        n_fallback = 1'b0;
                    end
                endcase
            end
            tpba_pkg::ST_TRY: begin
                n_rd_idx = '0;
                if (try_sys) begin
                    n_kind  = tpba_pkg::KIND_SYSTEM;
                    n_index = '0;
                    n_count = '0;
                    n_bytes = '0;
                end
            end
            tpba_pkg::ST_SCAN: begin
                n_chk_vld = issue;
                n_chk_idx = r_rd_idx;
                if (issue) begin
                    n_rd_idx  = r_rd_idx + tpba_pkg::t_widx'(1);
                    n_q_valid = r_valid[rd_addr];
                end
                if (hit) begin
                    n_chk_vld = 1'b0;
                    n_kind    = r_pool ? tpba_pkg::KIND_LARGE : tpba_pkg::KIND_SMALL;
                    n_index   = tpba_pkg::INDEX_W'(fidx);
                    n_count   = try_cnt;
                    n_bytes   = r_pool
                        ? tpba_pkg::BYTES_W'({fidx_x5, tpba_pkg::SMALL_SHIFT'(0)})
                        : tpba_pkg::BYTES_W'({fidx, tpba_pkg::SMALL_SHIFT'(0)});
                end else if (miss_end) begin
                    n_chk_vld = 1'b0;
                    if (r_fallback) begin
                        n_pool     = !r_pool;
                        n_fallback = 1'b0;
                    end else begin
                        n_kind  = tpba_pkg::KIND_FAILED;
                        n_index = '0;
                        n_count = '0;
                        n_bytes = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpba_pkg::ST_IDLE;
            r_chk_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            if (ram_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sm_need     <= n_sm_need;
        r_lg_need     <= n_lg_need;
        r_sm_big      <= n_sm_big;
        r_lg_big      <= n_lg_big;
        r_small_first <= n_small_first;
        r_prior       <= n_prior;
        r_reserved    <= n_reserved;
        r_pool        <= n_pool;
        r_fallback    <= n_fallback;
        r_sys         <= n_sys;
        r_rd_idx      <= n_rd_idx;
        r_chk_idx     <= n_chk_idx;
        r_q_valid     <= n_q_valid;
        r_kind        <= n_kind;
        r_index       <= n_index;
        r_count       <= n_count;
        r_bytes       <= n_bytes;
    end

    assign busy          = (r_state != tpba_pkg::ST_IDLE);
    assign o_valid       = (r_state == tpba_pkg::ST_RESP);
    assign o_result_kind = r_kind;
    assign o_block_index = r_index;
    assign o_block_count = r_count;
    assign o_byte_offset = r_bytes;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `TPBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted word did not raise busy")
    `TPBA_ASSERT_NEXT(a_resp_then_idle, i_clk, i_rst_n, o_valid, !busy && !o_valid, "result strobe did not end the item")
    `TPBA_ASSERT_NOW(a_no_grant_zero, i_clk, i_rst_n, o_valid && (o_result_kind == tpba_pkg::KIND_SYSTEM || o_result_kind == tpba_pkg::KIND_FAILED), o_block_count == '0 && o_block_index == '0 && o_byte_offset == '0, "non-grant result carries nonzero fields")
    `TPBA_ASSERT_NOW(a_grant_count, i_clk, i_rst_n, o_valid && (o_result_kind == tpba_pkg::KIND_SMALL || o_result_kind == tpba_pkg::KIND_LARGE), o_block_count != '0, "grant with empty run")

endmodule

@@ bench/tb_two_pool_bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the two-pool first-fit bitmap block allocator.
// Depends on tpba_pkg and the two_pool_bitmap_block_allocator RTL; keeps its own
// shadow bitmaps and predicts every grant from them.
module tb_two_pool_bitmap_block_allocator;
    import tpba_pkg::*;

    localparam int SMALL_BLOCK_BYTES = 'h200;
    localparam int LARGE_BLOCK_BYTES = 'hA00;
    localparam int RANDOM_ALLOCS     = 1700;
    localparam int RANDOM_NOISE      = 200;
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 500000;

    // Pool the predictor is working on; system memory lives outside the block.
    typedef enum int {POOL_SMALL, POOL_LARGE, POOL_SYSTEM} t_pool;

    // One expected grant, field for field as it leaves the block.
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] bytes;
    } t_grant;

    logic                 i_clk               = 1'b0;
    logic                 i_rst_n             = 1'b0;
    logic                 start               = 1'b0;
    logic [SIZE_W-1:0]    i_request_size      = '0;
    logic [PRIOR_W-1:0]   i_prior_kind        = '0;
    logic                 i_in_reserved_range = 1'b0;
    logic                 busy;
    logic                 o_valid;
    logic [KIND_W-1:0]    o_result_kind;
    logic [INDEX_W-1:0]   o_block_index;
    logic [COUNT_W-1:0]   o_block_count;
    logic [BYTES_W-1:0]   o_byte_offset;

    // Shadow copies of both bitmaps; a set bit is a used block.
    logic [MAP_W-1:0] small_shadow [SMALL_WORDS];
    logic [MAP_W-1:0] large_shadow [LARGE_WORDS];

    t_grant grants_due [$];   // predicted grants, oldest first
    t_grant head_grant;
    int     requests_sent  = 0;
    int     error_count    = 0;
    int     cycle_count    = 0;
    int     burst_left     = 0;
    int     kinds_seen [4] = '{0, 0, 0, 0};

    two_pool_bitmap_block_allocator uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_request_size      (i_request_size),
        .i_prior_kind        (i_prior_kind),
        .i_in_reserved_range (i_in_reserved_range),
        .o_valid             (o_valid),
        .o_result_kind       (o_result_kind),
        .o_block_index       (o_block_index),
        .o_block_count       (o_block_count),
        .o_byte_offset       (o_byte_offset)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // First-fit search over one pool: entries from 0 up, start offsets
    // from 0 up to 32 - need inclusive (the last position counts).
    // Claims the run in the shadow map on a hit.
    function automatic bit claim_run(input t_pool pool, input int need, output int first);
        int               entries;
        logic [MAP_W-1:0] entry;
        logic [MAP_W-1:0] mask;
        entries = (pool == POOL_SMALL) ? SMALL_WORDS : LARGE_WORDS;
        first   = 0;
        for (int w = 0; w < entries; w++) begin
            entry = (pool == POOL_SMALL) ? small_shadow[w] : large_shadow[w];
            for (int j = 0; j + need <= MAP_W; j++) begin
                mask = ((32'd1 << need) - 32'd1) << j;
                if ((entry & mask) == '0) begin
                    if (pool == POOL_SMALL) begin
                        small_shadow[w] = entry | mask;
                    end else begin
                        large_shadow[w] = entry | mask;
                    end
                    first = w * MAP_W + j;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Works out the grant for one accepted request word and updates the
    // shadow maps to match.
    function automatic t_grant predict_grant(input logic [SIZE_W-1:0]  size_in,
                                             input logic [PRIOR_W-1:0] prior,
                                             input logic               reserved);
        t_grant g;
        t_pool  pool;
        int     bytes;
        int     sm_need;
        int     lg_need;
        int     need;
        int     tries;
        int     first;
        g.kind  = KIND_FAILED;
        g.index = '0;
        g.count = '0;
        g.bytes = '0;
        // zero-byte requests still take one block
        bytes   = (size_in == '0) ? 1 : int'(size_in);
        sm_need = (bytes + SMALL_BLOCK_BYTES - 1) / SMALL_BLOCK_BYTES;
        lg_need = (bytes + LARGE_BLOCK_BYTES - 1) / LARGE_BLOCK_BYTES;
        tries   = 1;
        case (prior)
            PRIOR_NONE: begin
                if (reserved) begin
                    pool = POOL_SYSTEM;
                end else if (bytes < SMALL_SIZE_LIMIT) begin
                    pool = POOL_SMALL;
                end else begin
                    pool = POOL_LARGE;
                end
                tries = 2;   // one fallback to the other pool
            end
            PRIOR_SMALL: pool = POOL_LARGE;
            PRIOR_LARGE: pool = POOL_SMALL;
            default:     pool = POOL_SYSTEM;
        endcase
        for (int t = 0; t < tries; t++) begin
            if (t > 0) begin
                pool = (pool == POOL_SMALL) ? POOL_LARGE : POOL_SMALL;
            end
            need = (pool == POOL_SMALL) ? sm_need : lg_need;
            // runs longer than one map entry can hold go to system memory
            if (pool == POOL_SYSTEM || need > MAX_RUN) begin
                g.kind = KIND_SYSTEM;
                return g;
            end
            if (claim_run(pool, need, first)) begin
                g.kind  = (pool == POOL_SMALL) ? KIND_SMALL : KIND_LARGE;
                g.index = first[INDEX_W-1:0];
                g.count = need[COUNT_W-1:0];
                g.bytes = BYTES_W'(first * ((pool == POOL_SMALL) ? SMALL_BLOCK_BYTES
                                                                 : LARGE_BLOCK_BYTES));
                return g;
            end
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Presents one request word and holds it until start & !busy at an edge.
    // Called at a rising edge; start stays high on return so back-to-back
    // words need no dead cycle.
    task automatic send_request(input logic [SIZE_W-1:0]  size_in,
                                input logic [PRIOR_W-1:0] prior,
                                input logic               reserved);
        start               <= 1'b1;
        i_request_size      <= size_in;
        i_prior_kind        <= prior;
        i_in_reserved_range <= reserved;
        do @(posedge i_clk); while (busy !== 1'b0);
        grants_due.push_back(predict_grant(size_in, prior, reserved));
        requests_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Bursts of random length; most bursts are followed by a short gap so the
    // next word lands on a different cycle of the scan. Now and then a long
    // burst runs with no gap at all.
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 12));
            end
        end
        burst_left--;
    endtask

    // Run lengths lean short so the maps fill slowly and fragment.
    function automatic int pick_blocks(input int max_blocks);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_blocks)
                                           : $urandom_range(1, 4);
    endfunction

    // Random byte size that rounds up to exactly the given block count.
    function automatic logic [SIZE_W-1:0] size_for_blocks(input int blocks,
                                                          input int block_bytes);
        return SIZE_W'((blocks - 1) * block_bytes + $urandom_range(1, block_bytes));
    endfunction

    // ------------------------------------------------------------------
    // Result side: the receiver never stalls, so every strobe is checked
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (grants_due.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual kind %0d",
                         $time, o_result_kind);
                error_count++;
            end else begin
                head_grant = grants_due.pop_front();
                check_field("result_kind", int'(head_grant.kind),  int'(o_result_kind));
                check_field("block_index", int'(head_grant.index), int'(o_block_index));
                check_field("block_count", int'(head_grant.count), int'(o_block_count));
                check_field("byte_offset", int'(head_grant.bytes), int'(o_byte_offset));
                kinds_seen[head_grant.kind]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d grants outstanding",
                     $time, cycle_count, grants_due.size());
            $display("** two_pool_bitmap_block_allocator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero and one byte, block-size boundaries, and the largest size.
    task automatic test_size_extremes();
        send_request(24'h000000, PRIOR_NONE, 1'b0);
        send_request(24'h000001, PRIOR_NONE, 1'b0);
        send_request(24'h000200, PRIOR_NONE, 1'b0);
        send_request(24'h000201, PRIOR_NONE, 1'b0);
        send_request(24'hFFFFFF, PRIOR_NONE, 1'b0);
    endtask

    // Small/large split at 0x3C01, longest runs in each pool and one past
    // them, and the swapped pool for a previous small or large choice.
    task automatic test_pool_selection();
        send_request(24'h003C00, PRIOR_NONE,  1'b0);   // 30 small blocks
        send_request(24'h003C01, PRIOR_NONE,  1'b0);   // first large size
        send_request(24'h013600, PRIOR_NONE,  1'b0);   // 31 large blocks
        send_request(24'h013601, PRIOR_NONE,  1'b0);   // 32 large: system
        send_request(24'h000001, PRIOR_SMALL, 1'b0);   // tiny, but large pool
        send_request(24'h000200, PRIOR_SMALL, 1'b1);   // reserved ignored
        send_request(24'h003E00, PRIOR_LARGE, 1'b0);   // 31 small blocks
        send_request(24'h003E01, PRIOR_LARGE, 1'b0);   // 32 small: system
    endtask

    // Reserved requesters and previous system choices skip both pools.
    task automatic test_system_routing();
        send_request(24'h000001, PRIOR_NONE,   1'b1);
        send_request(24'h000001, PRIOR_SYSTEM, 1'b0);
        send_request(24'hFFFFFF, PRIOR_SYSTEM, 1'b1);
    endtask

    // Well-formed traffic with random content: mostly new requests sized for
    // real runs, plus swapped-pool retries and system-bound requests. With no
    // free path the maps fill up, so later words exercise fallback and failure.
    task automatic test_random_allocation(input int count);
        int                 pick;
        int                 blocks;
        logic [SIZE_W-1:0]  size_v;
        for (int n = 0; n < count; n++) begin
            pace_sender();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                blocks = pick_blocks(30);
                send_request(size_for_blocks(blocks, SMALL_BLOCK_BYTES), PRIOR_NONE, 1'b0);
            end else if (pick < 70) begin
                blocks = $urandom_range(7, 32);
                size_v = size_for_blocks(blocks, LARGE_BLOCK_BYTES);
                if (size_v < SMALL_SIZE_LIMIT) begin
                    size_v = SIZE_W'(SMALL_SIZE_LIMIT);
                end
                send_request(size_v, PRIOR_NONE, 1'b0);
            end else if (pick < 80) begin
                blocks = pick_blocks(32);
                send_request(size_for_blocks(blocks, LARGE_BLOCK_BYTES), PRIOR_SMALL,
                             1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
                blocks = pick_blocks(32);
                send_request(size_for_blocks(blocks, SMALL_BLOCK_BYTES), PRIOR_LARGE,
                             1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                send_request(SIZE_W'($urandom()), PRIOR_SYSTEM, 1'($urandom_range(0, 1)));
            end else begin
                send_request(SIZE_W'($urandom()), PRIOR_NONE, 1'b1);
            end
        end
    endtask

    // Unshaped words: every field fully random, so every size bit toggles.
    task automatic test_random_noise(input int count);
        for (int n = 0; n < count; n++) begin
            pace_sender();
            send_request(SIZE_W'($urandom()), PRIOR_W'($urandom()), 1'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (small_shadow[w]) small_shadow[w] = '0;
        foreach (large_shadow[w]) large_shadow[w] = '0;

        // Hold reset, then release it before the first word.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_size_extremes();
        test_pool_selection();
        test_system_routing();
        test_random_allocation(RANDOM_ALLOCS);
        test_random_noise(RANDOM_NOISE);

        // Drain: the watchdog bounds this wait.
        start <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        pause_sender(DRAIN_CYCLES);

        $display("Sent %0d requests through both pools, fallback and system routing.",
                 requests_sent);
        $display("Grants seen: %0d small, %0d large, %0d system, %0d failed; %0d errors.",
                 kinds_seen[KIND_SMALL], kinds_seen[KIND_LARGE], kinds_seen[KIND_SYSTEM],
                 kinds_seen[KIND_FAILED], error_count);
        if (error_count == 0) begin
            $display("** two_pool_bitmap_block_allocator: PASSED **");
        end else begin
            $display("** two_pool_bitmap_block_allocator: FAILED **");
        end
        $finish;
    end

endmodule
